FILE: rtl/pas_pkg.sv
// pas_pkg: shared widths, action and status codes for the positional array store.
// Used by pas_div and positional_array_store; no dependencies.
package pas_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int ACTION_W = 3;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 6;
  localparam int COUNT_W  = 7;
  localparam int TOTAL_W  = 38;
  localparam int AVG_W    = 40;
  localparam int FRAC_W   = 8;

  // dividend magnitude for the average: |total| scaled by 2^FRAC_W
  localparam int MAG_W    = TOTAL_W + FRAC_W;
  localparam int DCNT_W   = $clog2(MAG_W + 1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT   = 3'd0,
    ACT_DELETE   = 3'd1,
    ACT_LIST_ODD = 3'd2,
    ACT_LIST_ALL = 3'd3,
    ACT_STATS    = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_NONE    = 2'd3
  } status_t;

endpackage

FILE: rtl/pas_div.sv
// pas_div: signed (total * 2^FRAC_W) / count, truncated toward zero.
// Restoring divider, one quotient bit per cycle. Depends on pas_pkg.
module pas_div
  import pas_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [TOTAL_W-1:0] dividend,
  input  logic        [COUNT_W-1:0] divisor,
  output logic                      done,
  output logic signed [AVG_W-1:0]   quotient
);

  logic                    run_r;
  logic [DCNT_W-1:0]       cnt_r;
  logic                    neg_r;
  logic [COUNT_W-1:0]      div_r;
  logic [COUNT_W-1:0]      rem_r;
  logic [MAG_W-1:0]        quo_r;
  logic                    done_r;
  logic signed [AVG_W-1:0] quotient_r;

  logic [TOTAL_W-1:0]      abs_dvd;
  logic [COUNT_W:0]        trial;
  logic [COUNT_W:0]        diff;
  logic                    ge;
  logic [COUNT_W-1:0]      rem_nxt;
  logic [MAG_W-1:0]        quo_nxt;
  logic [MAG_W-1:0]        signed_q;

  assign abs_dvd  = dividend[TOTAL_W-1] ? (~dividend + 1'b1) : dividend;
  assign trial    = {rem_r, quo_r[MAG_W-1]};
  assign ge       = trial >= {1'b0, div_r};
  assign diff     = trial - {1'b0, div_r};
  assign rem_nxt  = ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
  assign quo_nxt  = {quo_r[MAG_W-2:0], ge};
  assign signed_q = neg_r ? (~quo_nxt + 1'b1) : quo_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= DCNT_W'(MAG_W);
        neg_r <= dividend[TOTAL_W-1];
        div_r <= divisor;
        rem_r <= '0;
        quo_r <= {abs_dvd, {FRAC_W{1'b0}}};
      end else if (run_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          run_r      <= 1'b0;
          done_r     <= 1'b1;
          quotient_r <= signed_q[AVG_W-1:0];
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quotient_r;

endmodule

FILE: rtl/positional_array_store.sv
// positional_array_store: ordered list of signed 32-bit values in one synchronous
// memory, with insert/delete at a position, listing and stats. Uses pas_pkg, pas_div.
//
// Input: a transaction is taken on the rising edge where start is high and busy is
//   low; in_action, in_position and in_value are sampled there.
// Results: each shows for one cycle with out_valid high; out_last marks the final
//   result of a transaction. The receiver cannot stall, so results leave as made.
// Steps per action after accept (N = count before):
//   Rejected insert/delete, empty list or empty stats: a single result, busy stays low.
//   Insert at p < N: entries N-1 down to p read in turn, each moved up one place
//   behind its registered read, then the new value written. Insert at p = N: no walk.
//   Delete at p: entry p read for the total, later ones moved down.
//   List: results follow one per cycle.
//   Stats: average from the bit-serial divider (46 quotient bits).
//   One transaction at a time; busy drops at the edge launching the final result.
// Reset: rst_n (synchronous) empties the list; count and total go to zero. Memory
//   contents are not cleared; entries at or above count are never used.
// Unknown action codes are taken and dropped without a result.
module positional_array_store
  import pas_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic        [ACTION_W-1:0] in_action,
  input  logic        [POS_W-1:0]    in_position,
  input  logic signed [VALUE_W-1:0]  in_value,
  output logic                       out_valid,
  output logic        [STATUS_W-1:0] out_status,
  output logic        [INDEX_W-1:0]  out_element_index,
  output logic signed [VALUE_W-1:0]  out_element_value,
  output logic        [COUNT_W-1:0]  out_count,
  output logic signed [TOTAL_W-1:0]  out_total,
  output logic signed [AVG_W-1:0]    out_average,
  output logic                       out_last
);

  localparam int AW = $clog2(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN,
    S_DIV
  } state_t;

  // element memory: one write and one registered read per cycle
  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [VALUE_W-1:0] rd_data_r;

  state_t                    state_r;
  action_t                   op_r;
  logic [POS_W-1:0]          pos_r;
  logic signed [VALUE_W-1:0] val_r;
  logic [COUNT_W-1:0]        count_r;
  logic signed [TOTAL_W-1:0] total_r;
  logic signed [VALUE_W-1:0] del_val_r;

  // walk: read pointer, step, and the read in flight
  logic [COUNT_W-1:0]        ptr_r;
  logic [COUNT_W-1:0]        step_r;
  logic                      more_r;
  logic                      rv_r;
  logic [AW-1:0]             raddr_r;
  logic                      rlast_r;

  logic                      out_valid_r;
  status_t                   out_status_r;
  logic [INDEX_W-1:0]        out_index_r;
  logic signed [VALUE_W-1:0] out_value_r;
  logic [COUNT_W-1:0]        out_count_r;
  logic signed [TOTAL_W-1:0] out_total_r;
  logic signed [AVG_W-1:0]   out_avg_r;
  logic                      out_last_r;

  logic                      accept;
  action_t                   act;
  logic [COUNT_W:0]          ptr_sum;
  logic                      stop;
  logic [COUNT_W-1:0]        ptr_next;
  logic [AW-1:0]             rd_addr;
  logic                      we;
  logic [AW-1:0]             waddr;
  logic [VALUE_W-1:0]        wdata;
  logic                      at_pos;
  logic                      div_start;
  logic                      div_done;
  logic signed [AVG_W-1:0]   div_q;

  assign accept  = start && (state_r == S_IDLE);
  assign act     = action_t'(in_action);
  assign ptr_sum = {1'b0, ptr_r} + {1'b0, step_r};
  // insert walks down to the position; others walk up to the last entry
  assign stop     = (op_r == ACT_INSERT) ? (ptr_r == pos_r) : (ptr_sum >= {1'b0, count_r});
  assign ptr_next = (op_r == ACT_INSERT) ? (ptr_r - 1'b1) : ptr_sum[COUNT_W-1:0];
  assign rd_addr  = ptr_r[AW-1:0];
  assign at_pos   = (raddr_r == pos_r[AW-1:0]);

  // write port: entry moves during the walk, new value at the end of insert
  always_comb begin
    we    = 1'b0;
    waddr = raddr_r;
    wdata = rd_data_r;
    if (state_r == S_RUN && rv_r && op_r == ACT_INSERT) begin
      we    = 1'b1;
      waddr = raddr_r + 1'b1;
    end else if (state_r == S_RUN && rv_r && op_r == ACT_DELETE && !at_pos) begin
      we    = 1'b1;
      waddr = raddr_r - 1'b1;
    end else if (state_r == S_FIN && op_r == ACT_INSERT) begin
      we    = 1'b1;
      waddr = pos_r[AW-1:0];
      wdata = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign div_start = accept && act == ACT_STATS && count_r != '0;

  pas_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (total_r),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      more_r      <= 1'b0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      out_index_r <= '0;
      out_value_r <= '0;
      out_avg_r   <= '0;
      out_count_r <= count_r;
      out_total_r <= total_r;
      out_last_r  <= 1'b1;
      case (state_r)
        S_IDLE: begin
          rv_r <= 1'b0;
          if (accept) begin
            op_r  <= act;
            pos_r <= in_position;
            val_r <= in_value;
            case (act)
              ACT_INSERT: begin
                ptr_r  <= count_r - 1'b1;
                step_r <= COUNT_W'(1);
                if (in_position > count_r) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= ST_BAD_POS;
                end else if (count_r >= COUNT_W'(CAPACITY)) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= ST_FULL;
                end else if (in_position == count_r) begin
                  state_r <= S_FIN;
                end else begin
                  more_r  <= 1'b1;
                  state_r <= S_RUN;
                end
              end
              ACT_DELETE: begin
                ptr_r  <= in_position;
                step_r <= COUNT_W'(1);
                if (in_position >= count_r) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= ST_BAD_POS;
                end else begin
                  more_r  <= 1'b1;
                  state_r <= S_RUN;
                end
              end
              ACT_LIST_ODD: begin
                ptr_r  <= COUNT_W'(1);
                step_r <= COUNT_W'(2);
                if (count_r < COUNT_W'(2)) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= ST_NONE;
                end else begin
                  more_r  <= 1'b1;
                  state_r <= S_RUN;
                end
              end
              ACT_LIST_ALL: begin
                ptr_r  <= '0;
                step_r <= COUNT_W'(1);
                if (count_r == '0) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= ST_NONE;
                end else begin
                  more_r  <= 1'b1;
                  state_r <= S_RUN;
                end
              end
              ACT_STATS: begin
                if (count_r == '0) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= ST_NONE;
                end else begin
                  state_r <= S_DIV;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_RUN: begin
          // issue side
          rv_r <= more_r;
          if (more_r) begin
            raddr_r <= rd_addr;
            rlast_r <= stop;
            more_r  <= !stop;
            ptr_r   <= ptr_next;
          end
          // data side: the read issued in the previous cycle
          if (rv_r) begin
            case (op_r)
              ACT_INSERT: begin
                if (rlast_r) begin
                  state_r <= S_FIN;
                end
              end
              ACT_DELETE: begin
                if (at_pos) begin
                  del_val_r <= rd_data_r;
                end
                if (rlast_r) begin
                  state_r <= S_FIN;
                end
              end
              default: begin
                out_valid_r  <= 1'b1;
                out_status_r <= ST_OK;
                out_index_r  <= INDEX_W'(raddr_r);
                out_value_r  <= rd_data_r;
                out_last_r   <= rlast_r;
                if (rlast_r) begin
                  state_r <= S_IDLE;
                end
              end
            endcase
          end
        end
        S_FIN: begin
          rv_r         <= 1'b0;
          out_valid_r  <= 1'b1;
          out_status_r <= ST_OK;
          if (op_r == ACT_INSERT) begin
            count_r     <= count_r + 1'b1;
            total_r     <= total_r + {{(TOTAL_W-VALUE_W){val_r[VALUE_W-1]}}, val_r};
            out_count_r <= count_r + 1'b1;
            out_total_r <= total_r + {{(TOTAL_W-VALUE_W){val_r[VALUE_W-1]}}, val_r};
          end else begin
            count_r     <= count_r - 1'b1;
            total_r     <= total_r - {{(TOTAL_W-VALUE_W){del_val_r[VALUE_W-1]}}, del_val_r};
            out_count_r <= count_r - 1'b1;
            out_total_r <= total_r - {{(TOTAL_W-VALUE_W){del_val_r[VALUE_W-1]}}, del_val_r};
          end
          state_r <= S_IDLE;
        end
        S_DIV: begin
          if (div_done) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_OK;
            out_avg_r    <= div_q;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_element_index = out_index_r;
  assign out_element_value = out_value_r;
  assign out_count         = out_count_r;
  assign out_total         = out_total_r;
  assign out_average       = out_avg_r;
  assign out_last          = out_last_r;

  // count never exceeds the memory depth
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(CAPACITY))
    else $error("count above capacity");

  // list changes always come with a result
  a_count_result: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(count_r) |-> out_valid)
    else $error("count changed without a result");

  // walk never writes the entry it is reading in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(we && more_r && state_r == S_RUN && waddr == rd_addr))
    else $error("memory read/write overlap on one entry");

  // a result that is not the last one leaves the block busy
  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("partial listing while idle");

  // error and empty results are single
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last)
    else $error("error result not marked last");

endmodule
